[rtl/assert_macros.svh]
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Expression that must never be true outside reset.
`define ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

[rtl/gprn_pkg.sv]
// Types and constants for the gray pixel random noise block.
package gprn_pkg;

	localparam int PIX_W      = 8;
	localparam int REM_W      = 8;
	localparam int DIV_W      = 9;
	localparam int AMP_W      = 8;
	localparam int THR_W      = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;
	localparam int PROD_W     = 15;
	localparam int LUMA_SUM_W = 23;
	localparam int GATE_REM_W = 7;

	typedef logic [PIX_W-1:0]      pix_t;
	typedef logic [REM_W-1:0]      rem_t;
	typedef logic [DIV_W-1:0]      div_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NOISE_AMPLITUDE   = 2'd0,
		REG_THRESHOLD_PERCENT = 2'd1
	} cfg_index_t;

	// fixed-point luma weights, sum of weights is 1 << LUMA_SHIFT
	localparam logic [13:0] W_RED      = 14'd4899;
	localparam logic [13:0] W_GREEN    = 14'd9617;
	localparam logic [13:0] W_BLUE     = 14'd1868;
	localparam logic [LUMA_SUM_W-1:0] LUMA_ROUND = 23'd8192;
	localparam int LUMA_SHIFT = 14;

	localparam logic [DIV_W-1:0]  GATE_MOD   = 9'd100;
	localparam logic [PROD_W-1:0] GATE_SCALE = 15'd100;
	localparam logic [PROD_W-1:0] THR_SCALE  = 15'd255;

endpackage

[rtl/gprn_mod_pipe.sv]
// Pipelined restoring remainder unit, one dividend bit per stage.
module gprn_mod_pipe #(
	parameter int DVD_W = 15
) (
	input  logic              clk,
	input  logic [DVD_W-1:0]  dividend,
	input  gprn_pkg::div_t    divisor,
	output gprn_pkg::rem_t    remainder
);
	import gprn_pkg::*;

	rem_t             rem_s [DVD_W];
	logic [DVD_W-1:0] dvd_s [DVD_W];
	div_t             div_s [DVD_W];

	for (genvar i = 0; i < DVD_W; i++) begin : g_stage
		logic [DVD_W-1:0] dvd_in;
		div_t             div_in;
		rem_t             rem_in;
		div_t             trial;
		div_t             diff;

		if (i == 0) begin : g_first
			assign dvd_in = dividend;
			assign div_in = divisor;
			assign rem_in = '0;
		end else begin : g_next
			assign dvd_in = dvd_s[i-1];
			assign div_in = div_s[i-1];
			assign rem_in = rem_s[i-1];
		end

		// partial remainder stays below the divisor, so it fits REM_W bits
		assign trial = {rem_in, dvd_in[DVD_W-1-i]};
		assign diff  = trial - div_in;

		always_ff @(posedge clk) begin
			dvd_s[i] <= dvd_in;
			div_s[i] <= div_in;
			rem_s[i] <= (trial >= div_in) ? diff[REM_W-1:0] : trial[REM_W-1:0];
		end
	end

	assign remainder = rem_s[DVD_W-1];

endmodule

[rtl/gprn_luma.sv]
// Two-stage luma computation: weighted products, then rounded sum.
module gprn_luma (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           valid_in,
	input  logic           tag_in,
	input  gprn_pkg::pix_t blue,
	input  gprn_pkg::pix_t green,
	input  gprn_pkg::pix_t red,
	output logic           valid_out,
	output logic           tag_out,
	output gprn_pkg::pix_t luma
);
	import gprn_pkg::*;

	logic                  valid_s1, valid_s2;
	logic                  tag_s1, tag_s2;
	logic [20:0]           pr_s1;
	logic [21:0]           pg_s1;
	logic [18:0]           pb_s1;
	pix_t                  luma_s2;
	logic [LUMA_SUM_W-1:0] sum;
	logic [LUMA_SUM_W-1:0] sum_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= valid_in;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		tag_s1 <= tag_in;
		pr_s1  <= 21'(red * W_RED);
		pg_s1  <= 22'(green * W_GREEN);
		pb_s1  <= 19'(blue * W_BLUE);
	end

	assign sum    = LUMA_SUM_W'(pr_s1) + LUMA_SUM_W'(pg_s1) + LUMA_SUM_W'(pb_s1) + LUMA_ROUND;
	assign sum_sh = sum >> LUMA_SHIFT;

	always_ff @(posedge clk) begin
		tag_s2  <= tag_s1;
		luma_s2 <= sum_sh[PIX_W-1:0];
	end

	assign valid_out = valid_s2;
	assign tag_out   = tag_s2;
	assign luma      = luma_s2;

endmodule

[rtl/gprn_delay.sv]
// Delay line for valid and sideband data, aligning them with the remainder unit.
module gprn_delay #(
	parameter int W     = 9,
	parameter int DEPTH = 13
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         valid_in,
	input  logic [W-1:0] data_in,
	output logic         valid_out,
	output logic [W-1:0] data_out
);
	logic         valid_s [DEPTH];
	logic [W-1:0] data_s  [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_tap
		logic         v_in;
		logic [W-1:0] d_in;

		if (i == 0) begin : g_first
			assign v_in = valid_in;
			assign d_in = data_in;
		end else begin : g_next
			assign v_in = valid_s[i-1];
			assign d_in = data_s[i-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i] <= 1'b0;
			end else begin
				valid_s[i] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			data_s[i] <= d_in;
		end
	end

	assign valid_out = valid_s[DEPTH-1];
	assign data_out  = data_s[DEPTH-1];

endmodule

[rtl/gray_pixel_random_noise.sv]
// Top level: BGR pixel to gray with random noise, fully pipelined.
//
// Usage:
//   Pixel channel: raise start with blue, green, red and the three random
//   words; the transaction is taken at any edge where start is high and busy
//   is low. busy stays low, so one pixel may be issued every cycle.
//   Result channel: done is high for exactly one cycle with gray_out and
//   noise_applied; the receiver must take it then, it cannot stall.
//   The pipeline depth comes from the amount remainder pipeline (modulo
//   amplitude+1), one random-word bit per stage, plus one output stage
//   for the gate compare and saturation. The gate word modulo 100 takes
//   two stages, a reciprocal multiply and then a subtract back, and rides
//   the delay line with the luma value.
//   Throughput: one pixel per cycle.
//   Configuration: cfg_valid/cfg_ready write channel, cfg_ready always high.
//   Index 0 is noise_amplitude, index 1 threshold_percent; other indexes are
//   ignored. Write only while no pixel is in flight.
//   Reset: arst_n clears both registers to 0 and empties the pipeline.
module gray_pixel_random_noise #(
	parameter int RAND_BITS = 15
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  gprn_pkg::pix_t                  blue,
	input  gprn_pkg::pix_t                  green,
	input  gprn_pkg::pix_t                  red,
	input  logic [RAND_BITS-1:0]            rand_gate,
	input  logic [RAND_BITS-1:0]            rand_sign,
	input  logic [RAND_BITS-1:0]            rand_amount,
	output logic                            done,
	output gprn_pkg::pix_t                  gray_out,
	output logic                            noise_applied,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [gprn_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  gprn_pkg::cfg_data_t             cfg_data
);
	import gprn_pkg::*;

	// floor(x / 100) == (x * GATE_RECIP) >> GATE_SH for every RAND_BITS-bit x
	localparam int GATE_SH = RAND_BITS + 7;
	localparam int RECIP_W = RAND_BITS + 1;
	localparam int MUL_W   = 2 * RAND_BITS + 1;
	localparam int QUO_W   = RAND_BITS - 6;
	localparam int SIDE_W  = PIX_W + 1 + GATE_REM_W;
	localparam logic [63:0] GATE_RECIP_FULL = ((64'd1 << GATE_SH) + 64'd99) / 64'd100;
	localparam logic [RECIP_W-1:0] GATE_RECIP = GATE_RECIP_FULL[RECIP_W-1:0];

	logic             accept;
	logic [AMP_W-1:0] noise_amplitude_q;
	logic [THR_W-1:0] threshold_percent_q;
	div_t             amp_div;

	logic [MUL_W-1:0]      gate_mul;
	logic [QUO_W-1:0]      gate_quo_s1;
	logic [RAND_BITS-1:0]  gate_word_s1;
	logic [RAND_BITS-1:0]  gate_back;
	logic [RAND_BITS-1:0]  gate_diff;
	logic [GATE_REM_W-1:0] gate_rem_s2;

	logic             luma_valid;
	logic             luma_sign;
	pix_t             luma_val;
	logic             valid_d;
	logic [SIDE_W-1:0] side_d;
	logic [GATE_REM_W-1:0] gate_rem;
	rem_t             step;

	logic [PROD_W-1:0] gate_prod;
	logic [PROD_W-1:0] thr_prod;
	logic              hit;
	logic [PIX_W:0]    sum9;
	logic [PIX_W:0]    diff9;
	pix_t              noisy;
	pix_t              y_d;

	logic done_q;
	pix_t gray_out_q;
	logic noise_applied_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			noise_amplitude_q   <= '0;
			threshold_percent_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_NOISE_AMPLITUDE: begin
					noise_amplitude_q <= cfg_data[AMP_W-1:0];
				end
				REG_THRESHOLD_PERCENT: begin
					threshold_percent_q <= cfg_data[THR_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign amp_div = {1'b0, noise_amplitude_q} + DIV_W'(1);

	// gate word modulo 100: quotient by reciprocal, then subtract back
	assign gate_mul = MUL_W'(rand_gate) * MUL_W'(GATE_RECIP);

	always_ff @(posedge clk) begin
		gate_quo_s1  <= gate_mul[MUL_W-1:GATE_SH];
		gate_word_s1 <= rand_gate;
	end

	assign gate_back = RAND_BITS'(gate_quo_s1) * RAND_BITS'(GATE_MOD);
	assign gate_diff = gate_word_s1 - gate_back;

	always_ff @(posedge clk) begin
		gate_rem_s2 <= gate_diff[GATE_REM_W-1:0];
	end

	gprn_luma u_luma (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_in  (accept),
		.tag_in    (rand_sign[0]),
		.blue      (blue),
		.green     (green),
		.red       (red),
		.valid_out (luma_valid),
		.tag_out   (luma_sign),
		.luma      (luma_val)
	);

	// luma and gate remainder take two stages; pad to the remainder pipeline depth
	gprn_delay #(
		.W     (SIDE_W),
		.DEPTH (RAND_BITS - 2)
	) u_delay (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_in  (luma_valid),
		.data_in   ({gate_rem_s2, luma_sign, luma_val}),
		.valid_out (valid_d),
		.data_out  (side_d)
	);

	gprn_mod_pipe #(
		.DVD_W (RAND_BITS)
	) u_amount_mod (
		.clk       (clk),
		.dividend  (rand_amount),
		.divisor   (amp_div),
		.remainder (step)
	);

	assign y_d       = side_d[PIX_W-1:0];
	assign gate_rem  = side_d[SIDE_W-1:PIX_W+1];
	assign gate_prod = PROD_W'(gate_rem) * GATE_SCALE;
	assign thr_prod  = PROD_W'(threshold_percent_q) * THR_SCALE;
	assign hit       = gate_prod <= thr_prod;
	assign sum9      = {1'b0, y_d} + {1'b0, step};
	assign diff9     = {1'b0, y_d} - {1'b0, step};

	always_comb begin
		if (!side_d[PIX_W]) begin
			noisy = sum9[PIX_W] ? {PIX_W{1'b1}} : sum9[PIX_W-1:0];
		end else begin
			noisy = diff9[PIX_W] ? '0 : diff9[PIX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		gray_out_q      <= hit ? noisy : y_d;
		noise_applied_q <= hit;
	end

	assign done          = done_q;
	assign gray_out      = gray_out_q;
	assign noise_applied = noise_applied_q;

endmodule

[rtl/gprn_checker.sv]
// Port-level checker for the gray pixel random noise block, with its bind.
`include "assert_macros.svh"

module gprn_checker #(
	parameter int RAND_BITS = 15
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 start,
	input logic                 busy,
	input logic [RAND_BITS-1:0] rand_gate,
	input logic                 done,
	input logic                 noise_applied,
	input logic                 cfg_valid,
	input logic                 cfg_ready
);
	localparam int LAT = RAND_BITS + 1;

	// every transaction taken is followed by done after LAT
	`ASSERT_CLK(a_latency, (start && !busy) |-> ##LAT done, "result missing after pixel")

	// no result without a pixel taken at the matching edge
	`ASSERT_CLK(a_no_spurious, done |-> $past(start && !busy, LAT), "result without pixel")

	// a zero gate word always passes the gate
	`ASSERT_CLK(a_gate_zero, (done && $past(rand_gate == '0, LAT)) |-> noise_applied,
		"zero gate word did not apply noise")

	`ASSERT_NEVER(a_cfg_ready, cfg_valid && !cfg_ready, "configuration write refused")

endmodule

bind gray_pixel_random_noise gprn_checker #(
	.RAND_BITS (RAND_BITS)
) u_gprn_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.rand_gate     (rand_gate),
	.done          (done),
	.noise_applied (noise_applied),
	.cfg_valid     (cfg_valid),
	.cfg_ready     (cfg_ready)
);
